>>> design/agga_pkg.sv
// ----------------------------------------------------------------------------
// agga_pkg: shared types and constants of the affine-gap alignment core
// Command codes, configuration register indexes, field widths and the control
// word that travels down the cell chain together with each item.
// ----------------------------------------------------------------------------
package agga_pkg;

  localparam int MAX_QUERY_DEF  = 64;
  localparam int COST_WIDTH_DEF = 16;

  localparam int SYM_W      = 8;
  localparam int QIDX_W     = 6;
  localparam int QLEN_W     = 7;
  localparam int PARAM_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int COL_W      = 16;
  localparam int SCORE_W    = 16;
  // Holds any row number of the largest supported chain (1024 rows).
  localparam int ROW_W      = 10;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_COLUMN = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_LENGTH  = 3'd0,
    CFG_MATCH_COST    = 3'd1,
    CFG_MISMATCH_COST = 3'd2,
    CFG_GAP_OPEN      = 3'd3,
    CFG_GAP_EXTEND    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [QLEN_W-1:0]  query_length;
    logic [PARAM_W-1:0] match_cost;
    logic [PARAM_W-1:0] mismatch_cost;
    logic [PARAM_W-1:0] gap_open;
    logic [PARAM_W-1:0] gap_extend;
  } cfg_t;

  // Control word handed from cell to cell. The costs of the item travel
  // beside it at the chain's cost width.
  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic [SYM_W-1:0]   symbol;
    logic [QIDX_W-1:0]  query_index;
    logic [ROW_W-1:0]   tap;
    logic [PARAM_W:0]   open_ext;
    logic [PARAM_W-1:0] ext;
    logic [PARAM_W-1:0] match_cost;
    logic [PARAM_W-1:0] mismatch_cost;
    logic [COL_W-1:0]   col;
  } link_t;

endpackage

>>> design/agga_if.sv
// ----------------------------------------------------------------------------
// agga_in_if / agga_out_if: item and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface agga_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [agga_pkg::SYM_W-1:0]    symbol;
  logic [agga_pkg::QIDX_W-1:0]   query_index;

  modport source (output valid, cmd, symbol, query_index, input ready);
  modport sink   (input valid, cmd, symbol, query_index, output ready);
endinterface

interface agga_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [agga_pkg::SCORE_W-1:0] column_score;
  logic [agga_pkg::COL_W-1:0]          column_number;

  modport source (output valid, column_score, column_number, input ready);
  modport sink   (input valid, column_score, column_number, output ready);
endinterface

>>> design/affine_gap_global_alignment_core.sv
// ----------------------------------------------------------------------------
// affine_gap_global_alignment_core: minimum-cost global alignment, affine gaps
// A chain of MAX_QUERY cells, one per query row, with a head stage that makes
// the top-row boundary of each column. Every item (query load, start, database
// symbol) enters the chain and moves one cell per cycle, so the core takes a
// new item in every cycle; a database symbol's result passes the head register,
// every cell and the output register, and leaves in order. Each item carries
// the configuration in force when it was taken. A result that waits at the
// output holds the whole chain, and the core takes no item in that cycle.
// ----------------------------------------------------------------------------
module affine_gap_global_alignment_core #(
  parameter int MAX_QUERY  = agga_pkg::MAX_QUERY_DEF,
  parameter int COST_WIDTH = agga_pkg::COST_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  agga_in_if.sink                             in_chan,
  agga_out_if.source                          out_chan,
  input  logic                                cfg_we,
  input  logic [agga_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [agga_pkg::CFG_DATA_W-1:0]     cfg_data
);

  function automatic logic signed [agga_pkg::SCORE_W-1:0] clamp_score(
    input logic signed [COST_WIDTH-1:0] s
  );
    logic signed [32:0] w;
    w = 33'(s);
    if (w > 33'sd32767) begin
      return 16'sh7fff;
    end else if (w < -33'sd32768) begin
      return 16'sh8000;
    end else begin
      return w[agga_pkg::SCORE_W-1:0];
    end
  endfunction

  agga_pkg::cfg_t                   cfg_r;
  logic                             adv;
  logic                             take;
  logic                             emit;
  logic                             out_valid_r;
  logic signed [agga_pkg::SCORE_W-1:0] out_score_r;
  logic [agga_pkg::COL_W-1:0]       out_col_r;

  agga_pkg::link_t                  lnk   [0:MAX_QUERY];
  logic signed [COST_WIDTH-1:0]     lnk_h [0:MAX_QUERY];
  logic signed [COST_WIDTH-1:0]     lnk_f [0:MAX_QUERY];
  logic signed [COST_WIDTH-1:0]     lnk_d [0:MAX_QUERY];
  logic signed [COST_WIDTH-1:0]     lnk_s [0:MAX_QUERY];

  // The chain moves whenever the output register is free or being emptied.
  assign adv           = !out_valid_r || out_chan.ready;
  assign take          = in_chan.valid && adv;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_length  <= 7'd1;
      cfg_r.match_cost    <= 8'd0;
      cfg_r.mismatch_cost <= 8'd1;
      cfg_r.gap_open      <= 8'd0;
      cfg_r.gap_extend    <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agga_pkg::CFG_QUERY_LENGTH:  cfg_r.query_length  <= cfg_data[agga_pkg::QLEN_W-1:0];
        agga_pkg::CFG_MATCH_COST:    cfg_r.match_cost    <= cfg_data;
        agga_pkg::CFG_MISMATCH_COST: cfg_r.mismatch_cost <= cfg_data;
        agga_pkg::CFG_GAP_OPEN:      cfg_r.gap_open      <= cfg_data;
        agga_pkg::CFG_GAP_EXTEND:    cfg_r.gap_extend    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  agga_entry #(
    .MAX_QUERY  (MAX_QUERY),
    .COST_WIDTH (COST_WIDTH)
  ) u_entry (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .take           (take),
    .in_cmd         (in_chan.cmd),
    .in_symbol      (in_chan.symbol),
    .in_query_index (in_chan.query_index),
    .cfg            (cfg_r),
    .lnk            (lnk[0]),
    .lnk_h          (lnk_h[0]),
    .lnk_f          (lnk_f[0]),
    .lnk_d          (lnk_d[0])
  );

  // The result lane picks up H at the selected row and rides to the bottom.
  assign lnk_s[0] = '0;

  for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
    agga_cell #(
      .ROW        (k),
      .COST_WIDTH (COST_WIDTH)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .adv    (adv),
      .up_ctl (lnk[k]),
      .up_h   (lnk_h[k]),
      .up_f   (lnk_f[k]),
      .up_d   (lnk_d[k]),
      .up_s   (lnk_s[k]),
      .dn_ctl (lnk[k+1]),
      .dn_h   (lnk_h[k+1]),
      .dn_f   (lnk_f[k+1]),
      .dn_d   (lnk_d[k+1]),
      .dn_s   (lnk_s[k+1])
    );
  end

  assign emit = lnk[MAX_QUERY].valid && (lnk[MAX_QUERY].cmd == agga_pkg::CMD_COLUMN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
      out_score_r <= clamp_score(lnk_s[MAX_QUERY]);
      out_col_r   <= lnk[MAX_QUERY].col;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.column_score  = out_score_r;
  assign out_chan.column_number = out_col_r;

  // A database symbol enters the chain with a column number of at least one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_chan.cmd == agga_pkg::CMD_COLUMN) |=>
      (lnk[0].valid && lnk[0].cmd == agga_pkg::CMD_COLUMN && lnk[0].col != '0))
    else $error("column item did not enter the chain with a column number");

  // A held output freezes the bottom of the chain.
  assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(lnk[MAX_QUERY].valid))
    else $error("chain moved while the output was stalled");

  // A new result only ever comes from a database symbol at the chain bottom.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(lnk[MAX_QUERY].valid && lnk[MAX_QUERY].cmd == agga_pkg::CMD_COLUMN))
    else $error("result raised without a database column at the chain bottom");

endmodule

>>> design/agga_cell.sv
// ----------------------------------------------------------------------------
// agga_cell: one query row of the alignment chain
// Holds the row's query symbol, best cost H and horizontal-gap cost E, updates
// them as an item passes, and registers the item for the next row.
// ----------------------------------------------------------------------------
module agga_cell #(
  parameter int ROW        = 0,
  parameter int COST_WIDTH = agga_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          adv,
  input  agga_pkg::link_t               up_ctl,
  input  logic signed [COST_WIDTH-1:0]  up_h,
  input  logic signed [COST_WIDTH-1:0]  up_f,
  input  logic signed [COST_WIDTH-1:0]  up_d,
  input  logic signed [COST_WIDTH-1:0]  up_s,
  output agga_pkg::link_t               dn_ctl,
  output logic signed [COST_WIDTH-1:0]  dn_h,
  output logic signed [COST_WIDTH-1:0]  dn_f,
  output logic signed [COST_WIDTH-1:0]  dn_d,
  output logic signed [COST_WIDTH-1:0]  dn_s
);

  // Four spare bits cover any cost plus open+extend without wrapping.
  localparam int SW = COST_WIDTH + 4;
  localparam logic signed [SW-1:0] C_HI = {{5{1'b0}}, {(COST_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] C_LO = {{5{1'b1}}, {(COST_WIDTH - 1){1'b0}}};

  localparam int CHI   = (COST_WIDTH >= 32) ? 32'h7fff_ffff : ((1 << (COST_WIDTH - 1)) - 1);
  localparam int H_RST = (ROW + 1 > CHI) ? CHI : ROW + 1;
  localparam int E_RST = (ROW + 2 > CHI) ? CHI : ROW + 2;
  localparam logic signed [COST_WIDTH-1:0] H_RST_V = COST_WIDTH'(H_RST);
  localparam logic signed [COST_WIDTH-1:0] E_RST_V = COST_WIDTH'(E_RST);

  localparam bit HAS_ADDR = (ROW < (1 << agga_pkg::QIDX_W));
  localparam logic [agga_pkg::QIDX_W-1:0] QADDR    = agga_pkg::QIDX_W'(ROW);
  localparam logic [agga_pkg::ROW_W-1:0]  ROW_ADDR = agga_pkg::ROW_W'(ROW);

  function automatic logic signed [COST_WIDTH-1:0] sat_c(input logic signed [SW-1:0] x);
    if (x > C_HI) begin
      return C_HI[COST_WIDTH-1:0];
    end else if (x < C_LO) begin
      return C_LO[COST_WIDTH-1:0];
    end else begin
      return x[COST_WIDTH-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ext_c(input logic signed [COST_WIDTH-1:0] c);
    return SW'(c);
  endfunction

  function automatic logic signed [COST_WIDTH-1:0] min_c(
    input logic signed [COST_WIDTH-1:0] a,
    input logic signed [COST_WIDTH-1:0] b
  );
    return (a < b) ? a : b;
  endfunction

  logic [agga_pkg::SYM_W-1:0]   qsym_r;
  logic signed [COST_WIDTH-1:0] h_r;
  logic signed [COST_WIDTH-1:0] e_r;
  agga_pkg::link_t              dn_ctl_r;
  logic signed [COST_WIDTH-1:0] dn_h_r;
  logic signed [COST_WIDTH-1:0] dn_f_r;
  logic signed [COST_WIDTH-1:0] dn_d_r;
  logic signed [COST_WIDTH-1:0] dn_s_r;

  logic signed [SW-1:0]         open_ext_s;
  logic signed [SW-1:0]         ext_s;
  logic signed [SW-1:0]         step_s;
  logic signed [COST_WIDTH-1:0] f_val;
  logic signed [COST_WIDTH-1:0] h_val;
  logic signed [COST_WIDTH-1:0] e_val;
  logic signed [COST_WIDTH-1:0] h_init;
  logic signed [COST_WIDTH-1:0] e_init;
  logic                         load_hit;

  always_comb begin
    open_ext_s = $signed(SW'(up_ctl.open_ext));
    ext_s      = $signed(SW'(up_ctl.ext));
    step_s     = (qsym_r == up_ctl.symbol) ? SW'($signed(up_ctl.match_cost))
                                           : SW'($signed(up_ctl.mismatch_cost));
    // Vertical gap, then the best cost of this row, then the gap carried right.
    f_val  = min_c(sat_c(ext_c(up_h) + open_ext_s), sat_c(ext_c(up_f) + ext_s));
    h_val  = min_c(min_c(sat_c(ext_c(up_d) + step_s), e_r), f_val);
    e_val  = min_c(sat_c(ext_c(h_val) + open_ext_s), sat_c(ext_c(e_r) + ext_s));
    // Boundary column: the row above passes its own H(i-1,0) down.
    h_init = sat_c(ext_c(up_h) + ext_s);
    e_init = sat_c(ext_c(h_init) + open_ext_s);
    load_hit = HAS_ADDR && (up_ctl.query_index == QADDR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r            <= H_RST_V;
      e_r            <= E_RST_V;
      dn_ctl_r.valid <= 1'b0;
    end else if (adv) begin
      dn_ctl_r <= up_ctl;
      dn_h_r   <= up_h;
      dn_f_r   <= up_f;
      dn_d_r   <= up_d;
      dn_s_r   <= up_s;
      if (up_ctl.valid) begin
        unique case (up_ctl.cmd)
          agga_pkg::CMD_LOAD: begin
            if (load_hit) begin
              qsym_r <= up_ctl.symbol;
            end
          end
          agga_pkg::CMD_START: begin
            h_r    <= h_init;
            e_r    <= e_init;
            dn_h_r <= h_init;
          end
          agga_pkg::CMD_COLUMN: begin
            h_r    <= h_val;
            e_r    <= e_val;
            dn_h_r <= h_val;
            dn_f_r <= f_val;
            dn_d_r <= h_r;
            if (up_ctl.tap == ROW_ADDR) begin
              dn_s_r <= h_val;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign dn_ctl = dn_ctl_r;
  assign dn_h   = dn_h_r;
  assign dn_f   = dn_f_r;
  assign dn_d   = dn_d_r;
  assign dn_s   = dn_s_r;

endmodule

>>> design/agga_entry.sv
// ----------------------------------------------------------------------------
// agga_entry: head of the alignment chain
// Keeps the column count, works out the top-row boundary costs of each column
// and registers the item with the configuration it is to be computed with.
// ----------------------------------------------------------------------------
module agga_entry #(
  parameter int MAX_QUERY  = agga_pkg::MAX_QUERY_DEF,
  parameter int COST_WIDTH = agga_pkg::COST_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  logic                              take,
  input  logic [1:0]                        in_cmd,
  input  logic [agga_pkg::SYM_W-1:0]        in_symbol,
  input  logic [agga_pkg::QIDX_W-1:0]       in_query_index,
  input  agga_pkg::cfg_t                    cfg,
  output agga_pkg::link_t                   lnk,
  output logic signed [COST_WIDTH-1:0]      lnk_h,
  output logic signed [COST_WIDTH-1:0]      lnk_f,
  output logic signed [COST_WIDTH-1:0]      lnk_d
);

  localparam logic [33:0] CHI_U = 34'((64'd1 << (COST_WIDTH - 1)) - 64'd1);

  // Boundary sums are never negative, so only the top needs clamping.
  function automatic logic [COST_WIDTH-1:0] sat_pos(input logic [25:0] x);
    if (34'(x) > CHI_U) begin
      return CHI_U[COST_WIDTH-1:0];
    end else begin
      return COST_WIDTH'(x);
    end
  endfunction

  logic [agga_pkg::COL_W-1:0]   column_count_r;
  logic [agga_pkg::COL_W-1:0]   column_count_nxt;
  agga_pkg::link_t              lnk_r;
  agga_pkg::link_t              lnk_nxt;
  logic signed [COST_WIDTH-1:0] lnk_h_r;
  logic signed [COST_WIDTH-1:0] lnk_f_r;
  logic signed [COST_WIDTH-1:0] lnk_d_r;
  logic signed [COST_WIDTH-1:0] lnk_h_nxt;
  logic signed [COST_WIDTH-1:0] lnk_f_nxt;
  logic signed [COST_WIDTH-1:0] lnk_d_nxt;

  logic                         at_max;
  logic [agga_pkg::COL_W-1:0]   col_j;
  logic [23:0]                  prod;
  logic [24:0]                  jr;
  logic [25:0]                  sum_h;
  logic [25:0]                  sum_f;
  logic [25:0]                  sum_d;
  logic [agga_pkg::ROW_W-1:0]   tap;

  always_comb begin
    at_max = (column_count_r == '1);
    col_j  = at_max ? column_count_r : column_count_r + 16'd1;
    prod   = 24'(column_count_r) * 24'(cfg.gap_extend);
    // j*r follows from (j-1)*r, so one product serves both boundaries.
    jr     = at_max ? 25'(prod) : 25'(prod) + 25'(cfg.gap_extend);
    sum_h  = 26'(cfg.gap_open) + 26'(jr);
    sum_f  = sum_h + 26'(cfg.gap_open);
    sum_d  = 26'(cfg.gap_open) + 26'(prod);

    if (cfg.query_length == '0) begin
      tap = '0;
    end else if (32'(cfg.query_length) > MAX_QUERY) begin
      tap = agga_pkg::ROW_W'(MAX_QUERY - 1);
    end else begin
      tap = agga_pkg::ROW_W'(cfg.query_length - 7'd1);
    end

    lnk_nxt.valid         = take;
    lnk_nxt.cmd           = agga_pkg::cmd_t'(in_cmd);
    lnk_nxt.symbol        = in_symbol;
    lnk_nxt.query_index   = in_query_index;
    lnk_nxt.tap           = tap;
    lnk_nxt.open_ext      = 9'(cfg.gap_open) + 9'(cfg.gap_extend);
    lnk_nxt.ext           = cfg.gap_extend;
    lnk_nxt.match_cost    = cfg.match_cost;
    lnk_nxt.mismatch_cost = cfg.mismatch_cost;
    lnk_nxt.col           = col_j;

    column_count_nxt = column_count_r;
    lnk_h_nxt        = sat_pos(26'(cfg.gap_open));
    lnk_f_nxt        = sat_pos(sum_f);
    lnk_d_nxt        = (column_count_r == '0) ? '0 : sat_pos(sum_d);
    if (take) begin
      unique case (lnk_nxt.cmd)
        agga_pkg::CMD_START:  column_count_nxt = '0;
        agga_pkg::CMD_COLUMN: begin
          column_count_nxt = col_j;
          lnk_h_nxt        = sat_pos(sum_h);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      lnk_r.valid    <= 1'b0;
    end else if (adv) begin
      column_count_r <= column_count_nxt;
      lnk_r          <= lnk_nxt;
      lnk_h_r        <= lnk_h_nxt;
      lnk_f_r        <= lnk_f_nxt;
      lnk_d_r        <= lnk_d_nxt;
    end
  end

  assign lnk   = lnk_r;
  assign lnk_h = lnk_h_r;
  assign lnk_f = lnk_f_r;
  assign lnk_d = lnk_d_r;

endmodule

>>> verif/affine_gap_global_alignment_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// affine_gap_global_alignment_core_test: self-checking bench for the core
// Loads query rows, drives starts and database symbols into the item channel.
// Every column result is checked against a behavioral model of the affine-gap
// recurrence or a fixed value, under changing costs and random flow control.
// ----------------------------------------------------------------------------
module affine_gap_global_alignment_core_test;

  localparam int ROWS = agga_pkg::MAX_QUERY_DEF;
  // Pipeline depth of the chain plus some margin.
  localparam int DRAIN_CYCLES = ROWS + 8;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int SCORE_MAX = 32767;
  localparam int SCORE_MIN = -32768;
  localparam int COUNT_MAX = 65535;
  localparam int PHASE_ITEMS = 130;

  typedef struct {
    bit                 is_write;
    agga_pkg::cfg_reg_t reg_sel;
    logic [7:0]         reg_val;
    logic [1:0]         cmd;
    logic [7:0]         sym;
    logic [5:0]         idx;
    bit                 known;
    logic signed [15:0] known_score;
    logic [15:0]        known_col;
  } plan_step_t;

  typedef struct {
    logic signed [15:0] score;
    logic [15:0]        col;
  } column_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_we;
  logic [agga_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [agga_pkg::CFG_DATA_W-1:0] cfg_data;

  agga_in_if  in_chan();
  agga_out_if out_chan();

  affine_gap_global_alignment_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Model of the core: query rows, per-row H and E, column counter, registers.
  logic [7:0]        query_row_sym [ROWS];
  int                best_cost [ROWS];
  int                horiz_gap [ROWS];
  int                columns_done;
  logic [6:0]        query_len_r;
  logic signed [7:0] match_r;
  logic signed [7:0] mismatch_r;
  logic [7:0]        open_r;
  logic [7:0]        extend_r;

  column_result_t due_columns [$];
  plan_step_t     plan [$];
  int             error_count = 0;
  int             src_idle_pct = 15;
  int             sink_idle_pct = 83;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clip16(longint v);
    if (v > SCORE_MAX) return SCORE_MAX;
    if (v < SCORE_MIN) return SCORE_MIN;
    return int'(v);
  endfunction

  function automatic int min_of(int a, int b);
    return (a < b) ? a : b;
  endfunction

  function automatic int rows_in_use();
    if (query_len_r == 0) return 1;
    if (query_len_r > ROWS) return ROWS;
    return int'(query_len_r);
  endfunction

  function automatic void restart_alignment();
    longint q;
    longint r;
    int     h0;
    int     e0;
    q = open_r;
    r = extend_r;
    columns_done = 0;
    for (int k = 0; k < ROWS; k++) begin
      h0 = clip16(q + longint'(k + 1) * r);
      e0 = clip16(2 * q + longint'(k + 1) * r);
      best_cost[k] = h0;
      horiz_gap[k] = min_of(clip16(h0 + q + r), clip16(e0 + r));
    end
  endfunction

  // Advances the wavefront by one database column and returns the last used row.
  function automatic column_result_t score_next_column(logic [7:0] sym);
    column_result_t res;
    longint q;
    longint r;
    longint s;
    int     prev;
    int     j;
    int     diag;
    int     h_up;
    int     f_up;
    int     old_h;
    int     e;
    int     f;
    int     h;
    q = open_r;
    r = extend_r;
    prev = columns_done;
    j = (prev < COUNT_MAX) ? prev + 1 : COUNT_MAX;
    columns_done = j;
    diag = (prev == 0) ? 0 : clip16(q + longint'(prev) * r);
    h_up = clip16(q + longint'(j) * r);
    f_up = clip16(2 * q + longint'(j) * r);
    for (int k = 0; k < ROWS; k++) begin
      s = (query_row_sym[k] == sym) ? longint'(match_r) : longint'(mismatch_r);
      old_h = best_cost[k];
      e = horiz_gap[k];
      f = min_of(clip16(h_up + q + r), clip16(f_up + r));
      h = min_of(min_of(clip16(diag + s), e), f);
      horiz_gap[k] = min_of(clip16(h + q + r), clip16(e + r));
      best_cost[k] = h;
      diag = old_h;
      h_up = h;
      f_up = f;
    end
    res.score = 16'(best_cost[rows_in_use() - 1]);
    res.col = 16'(j);
    return res;
  endfunction

  function automatic plan_step_t item_step(logic [1:0] cmd, logic [7:0] sym,
                                           logic [5:0] idx);
    plan_step_t st;
    st.is_write = 1'b0;
    st.reg_sel = agga_pkg::CFG_QUERY_LENGTH;
    st.reg_val = 8'h00;
    st.cmd = cmd;
    st.sym = sym;
    st.idx = idx;
    st.known = 1'b0;
    st.known_score = 16'sd0;
    st.known_col = 16'd0;
    return st;
  endfunction

  function automatic plan_step_t known_step(logic [7:0] sym, logic signed [15:0] score,
                                            logic [15:0] col);
    plan_step_t st;
    st = item_step(agga_pkg::CMD_COLUMN, sym, 6'd0);
    st.known = 1'b1;
    st.known_score = score;
    st.known_col = col;
    return st;
  endfunction

  function automatic plan_step_t write_step(agga_pkg::cfg_reg_t sel, logic [7:0] val);
    plan_step_t st;
    st = item_step(agga_pkg::CMD_LOAD, 8'h00, 6'd0);
    st.is_write = 1'b1;
    st.reg_sel = sel;
    st.reg_val = val;
    return st;
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 200) $display("ERROR at %0t: %s", $time, what);
  endtask

  // Presents one item, waits for its transfer and advances the model at it.
  task automatic send_item(input plan_step_t st);
    column_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.cmd <= st.cmd;
    in_chan.symbol <= st.sym;
    in_chan.query_index <= st.idx;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    case (st.cmd)
      agga_pkg::CMD_LOAD: query_row_sym[st.idx] = st.sym;
      agga_pkg::CMD_START: restart_alignment();
      agga_pkg::CMD_COLUMN: begin
        res = score_next_column(st.sym);
        if (st.known) begin
          res.score = st.known_score;
          res.col = st.known_col;
        end
        due_columns.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Stops sending and waits until the chain has emptied.
  task automatic drain_core();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (due_columns.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input agga_pkg::cfg_reg_t sel, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= val;
    @(posedge clk);
    case (sel)
      agga_pkg::CFG_QUERY_LENGTH:  query_len_r = val[6:0];
      agga_pkg::CFG_MATCH_COST:    match_r = val;
      agga_pkg::CFG_MISMATCH_COST: mismatch_r = val;
      agga_pkg::CFG_GAP_OPEN:      open_r = val;
      agga_pkg::CFG_GAP_EXTEND:    extend_r = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_costs(input logic [6:0] qlen, input logic [7:0] mc,
                            input logic [7:0] mmc, input logic [7:0] go,
                            input logic [7:0] ge);
    write_register(agga_pkg::CFG_QUERY_LENGTH, {1'b0, qlen});
    write_register(agga_pkg::CFG_MATCH_COST, mc);
    write_register(agga_pkg::CFG_MISMATCH_COST, mmc);
    write_register(agga_pkg::CFG_GAP_OPEN, go);
    write_register(agga_pkg::CFG_GAP_EXTEND, ge);
  endtask

  // Result side: random stalls, and each transfer is compared in order.
  initial begin
    column_result_t want;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
        if (due_columns.size() == 0) begin
          report_mismatch($sformatf("column %0d arrived with nothing outstanding",
                                    out_chan.column_number));
        end else begin
          want = due_columns.pop_front();
          if (out_chan.column_score !== want.score)
            report_mismatch($sformatf("column %0d: score %0d, expected %0d", want.col,
                                      out_chan.column_score, want.score));
          if (out_chan.column_number !== want.col)
            report_mismatch($sformatf("column number %0d, expected %0d",
                                      out_chan.column_number, want.col));
        end
      end
      out_chan.ready <= (rst_n === 1'b1) && ($urandom_range(99) >= sink_idle_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    plan_step_t st;
    int         counted;
    int         eff;
    int         n_loads;
    int         n_cols;
    int         pick;
    logic [6:0] qlen;
    logic [7:0] mc;
    logic [7:0] mmc;
    logic [7:0] go;
    logic [7:0] ge;
    logic [7:0] sym;

    in_chan.valid = 1'b0;
    in_chan.cmd = agga_pkg::CMD_LOAD;
    in_chan.symbol = 8'h00;
    in_chan.query_index = 6'd0;
    cfg_we = 1'b0;
    cfg_index = agga_pkg::CFG_QUERY_LENGTH;
    cfg_data = 8'h00;

    foreach (query_row_sym[k]) query_row_sym[k] = 8'h00;
    query_len_r = 7'd1;
    match_r = 8'sd0;
    mismatch_r = 8'sd1;
    open_r = 8'd0;
    extend_r = 8'd1;
    restart_alignment();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Every query row is written before any column may read it.
    for (int k = 0; k < ROWS; k++)
      send_item(item_step(agga_pkg::CMD_LOAD, 8'($urandom_range(255)), 6'(k)));

    // Reset registers first, with a column before any start.
    plan.push_back(item_step(agga_pkg::CMD_LOAD, 8'h41, 6'd0));
    plan.push_back(known_step(8'h41, 16'sd0, 16'd1));
    plan.push_back(known_step(8'h42, 16'sd1, 16'd2));
    plan.push_back(item_step(CMD_UNUSED, 8'hFF, 6'd63));
    plan.push_back(known_step(8'h41, 16'sd2, 16'd3));
    plan.push_back(item_step(agga_pkg::CMD_START, 8'h00, 6'd0));
    plan.push_back(known_step(8'h41, 16'sd0, 16'd1));
    plan.push_back(item_step(agga_pkg::CMD_LOAD, 8'hFF, 6'd63));
    plan.push_back(item_step(agga_pkg::CMD_LOAD, 8'h00, 6'd0));
    // A zero length acts as one row.
    plan.push_back(write_step(agga_pkg::CFG_QUERY_LENGTH, 8'd0));
    plan.push_back(item_step(agga_pkg::CMD_START, 8'h00, 6'd0));
    plan.push_back(known_step(8'h00, 16'sd0, 16'd1));
    plan.push_back(write_step(agga_pkg::CFG_QUERY_LENGTH, 8'd64));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'hFF, 6'd21));
    plan.push_back(write_step(agga_pkg::CFG_QUERY_LENGTH, 8'd127));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'hAA, 6'd42));
    plan.push_back(write_step(agga_pkg::CFG_MATCH_COST, 8'h80));
    plan.push_back(write_step(agga_pkg::CFG_MISMATCH_COST, 8'h7F));
    plan.push_back(write_step(agga_pkg::CFG_GAP_OPEN, 8'hFF));
    plan.push_back(write_step(agga_pkg::CFG_GAP_EXTEND, 8'hFF));
    plan.push_back(item_step(agga_pkg::CMD_START, 8'hFF, 6'd63));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'h00, 6'd0));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'hFF, 6'd0));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'h55, 6'd0));
    // Costs change in the middle of an alignment.
    plan.push_back(write_step(agga_pkg::CFG_MATCH_COST, 8'h7F));
    plan.push_back(write_step(agga_pkg::CFG_MISMATCH_COST, 8'h80));
    plan.push_back(write_step(agga_pkg::CFG_GAP_OPEN, 8'h00));
    plan.push_back(write_step(agga_pkg::CFG_GAP_EXTEND, 8'h00));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'h00, 6'd0));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'h13, 6'd0));
    plan.push_back(item_step(agga_pkg::CMD_LOAD, 8'h5A, 6'd42));
    plan.push_back(item_step(agga_pkg::CMD_COLUMN, 8'h5A, 6'd21));

    foreach (plan[n]) begin
      if (plan[n].is_write) begin
        drain_core();
        write_register(plan[n].reg_sel, plan[n].reg_val);
      end else begin
        send_item(plan[n]);
      end
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 83;
        sink_idle_pct = 15;
      end
      if (ph == 4) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      drain_core();
      case (ph)
        0: load_costs(7'd64, 8'h80, 8'h7F, 8'h00, 8'hFF);
        1: load_costs(7'd1, 8'h7F, 8'h80, 8'hFF, 8'h00);
        default: begin
          pick = $urandom_range(9);
          if (pick == 0) qlen = 7'd0;
          else if (pick == 1) qlen = 7'($urandom_range(127, 65));
          else qlen = 7'($urandom_range(64, 1));
          if ($urandom_range(1) == 1) begin
            mc = 8'($urandom_range(255));
            mmc = 8'($urandom_range(255));
          end else begin
            mc = 8'(int'($urandom_range(8)) - 8);
            mmc = 8'($urandom_range(8));
          end
          go = ($urandom_range(1) == 1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
          ge = ($urandom_range(1) == 1) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
          load_costs(qlen, mc, mmc, go, ge);
        end
      endcase

      counted = 0;
      while (counted < PHASE_ITEMS) begin
        eff = rows_in_use();
        if ($urandom_range(99) < 80) begin
          // A well-formed alignment, sometimes continuing without a start.
          if ($urandom_range(99) < 85) begin
            send_item(item_step(agga_pkg::CMD_START, 8'($urandom_range(255)),
                                6'($urandom_range(63))));
            counted++;
          end
          n_loads = $urandom_range(3);
          repeat (n_loads) begin
            send_item(item_step(agga_pkg::CMD_LOAD, 8'($urandom_range(255)),
                                6'($urandom_range(eff - 1))));
            counted++;
          end
          n_cols = $urandom_range(24, 1);
          repeat (n_cols) begin
            if ($urandom_range(99) < 60) sym = query_row_sym[$urandom_range(eff - 1)];
            else sym = 8'($urandom_range(255));
            send_item(item_step(agga_pkg::CMD_COLUMN, sym, 6'($urandom_range(63))));
            counted++;
          end
        end else begin
          st = item_step(2'($urandom_range(3)), 8'($urandom_range(255)),
                         6'($urandom_range(63)));
          send_item(st);
          if (st.cmd != CMD_UNUSED) counted++;
        end
      end
    end

    drain_core();

    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
